/* src/rolling_key_xor_stream_cipher_defines.svh */
// ----------------------------------------------------------------------------
// rolling_key_xor_stream_cipher_defines
// Assertion helpers shared by the cipher's modules.
// ----------------------------------------------------------------------------
`ifndef ROLLING_KEY_XOR_STREAM_CIPHER_DEFINES_SVH
`define ROLLING_KEY_XOR_STREAM_CIPHER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define RKX_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rkx assertion failed");

// Next-cycle implication, ignored while reset is held.
`define RKX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rkx assertion failed");

`endif

/* src/rkx_pkg.sv */
// ----------------------------------------------------------------------------
// rkx_pkg
// Types and constants shared by the rolling-key XOR stream cipher modules.
// ----------------------------------------------------------------------------
package rkx_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [3:0]  HEADER_LEN    = 4'd8;
    localparam logic [31:0] MAGIC_DEFAULT = 32'h4F4D_4252;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
    localparam logic [1:0] STATUS_SHORT     = 2'd2;

    localparam logic [2:0] REG_KEY_SEED      = 3'd0;
    localparam logic [2:0] REG_DECRYPT_MODE  = 3'd1;
    localparam logic [2:0] REG_HEADER_ENABLE = 3'd2;
    localparam logic [2:0] REG_KEY_MASK      = 3'd3;
    localparam logic [2:0] REG_MAGIC_WORD    = 3'd4;

    typedef struct packed {
        logic [31:0] key_seed;
        logic        decrypt_mode;
        logic        header_enable;
        logic [31:0] key_mask;
        logic [31:0] magic_word;
    } t_cfg;

    typedef struct packed {
        logic [7:0]  data;
        logic        data_valid;
        logic        last;
        logic [1:0]  status;
        logic [31:0] rkey;
    } t_result;

    // One queued job: a single result, optionally preceded by eight header bytes.
    typedef struct packed {
        logic        hdr;
        logic [31:0] magic;
        logic [31:0] hdr_key;
        t_result     res;
    } t_job;

endpackage

/* src/rkx_fifo.sv */
// ----------------------------------------------------------------------------
// rkx_fifo
// Short job queue between the front and back parts of the cipher.
// ----------------------------------------------------------------------------
`include "rolling_key_xor_stream_cipher_defines.svh"

module rkx_fifo #(
    parameter int unsigned DEPTH = rkx_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rkx_pkg::t_job i_job,
    input  logic          i_pop,
    output rkx_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    rkx_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    `RKX_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT)
    `RKX_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)

endmodule

/* src/rkx_front.sv */
// ----------------------------------------------------------------------------
// rkx_front
// Accepts input bytes, tracks the key and header state and issues jobs.
// ----------------------------------------------------------------------------
`include "rolling_key_xor_stream_cipher_defines.svh"

module rkx_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rkx_pkg::t_cfg i_cfg,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [7:0]    i_data,
    input  logic          i_last,
    input  logic          i_queue_full,
    output logic          o_push,
    output rkx_pkg::t_job o_job
);

    logic [31:0] r_key, n_key;
    logic [1:0]  r_pos, n_pos;
    logic [3:0]  r_count, n_count;
    logic [63:0] r_shift, n_shift;
    logic        r_err, n_err;

    logic        accept;
    logic        has_job;
    logic        hdr_dec;
    logic [63:0] shift_ins;
    logic [31:0] hdr_key;
    logic        hdr_bad;
    logic [31:0] cur_key;
    logic [1:0]  cur_pos;
    logic [31:0] key_sh;
    logic [7:0]  cipher;
    logic [7:0]  ct;
    logic [31:0] key_next;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign o_push     = accept && has_job;
    assign hdr_dec    = i_cfg.decrypt_mode && i_cfg.header_enable;

    always_comb begin
        shift_ins = r_shift | ({56'd0, i_data} << {r_count[2:0], 3'b000});
        hdr_key   = shift_ins[63:32] ^ i_cfg.key_mask;
        hdr_bad   = (shift_ins[31:0] != i_cfg.magic_word);

        // Outside header decryption the first byte of a message restarts the key.
        if (!hdr_dec && (r_count == 4'd0)) begin
            cur_key = i_cfg.key_seed;
            cur_pos = 2'd0;
        end else begin
            cur_key = r_key;
            cur_pos = r_pos;
        end
        key_sh   = cur_key >> {cur_pos, 3'b000};
        cipher   = i_data ^ key_sh[7:0];
        ct       = i_cfg.decrypt_mode ? i_data : cipher;
        key_next = {cur_key[24:0], cur_key[31:25]} ^ {24'd0, ct};

        n_key   = r_key;
        n_pos   = r_pos;
        n_count = r_count;
        n_shift = r_shift;
        n_err   = r_err;
        has_job = 1'b0;
        o_job   = '0;

        if (hdr_dec) begin
            if (r_count < rkx_pkg::HEADER_LEN) begin
                n_count = r_count + 4'd1;
                n_shift = shift_ins;
                if (r_count == rkx_pkg::HEADER_LEN - 4'd1) begin
                    n_err   = r_err | hdr_bad;
                    n_shift = {hdr_key, shift_ins[31:0]};
                    n_key   = hdr_key;
                    n_pos   = 2'd0;
                    if (i_last) begin
                        has_job        = 1'b1;
                        o_job.res.last = 1'b1;
                        if (r_err || hdr_bad) begin
                            o_job.res.status = rkx_pkg::STATUS_BAD_MAGIC;
                        end else begin
                            o_job.res.status = rkx_pkg::STATUS_OK;
                            o_job.res.rkey   = hdr_key;
                        end
                    end
                end else if (i_last) begin
                    has_job          = 1'b1;
                    o_job.res.last   = 1'b1;
                    o_job.res.status = rkx_pkg::STATUS_SHORT;
                end
            end else if (r_err) begin
                if (i_last) begin
                    has_job          = 1'b1;
                    o_job.res.last   = 1'b1;
                    o_job.res.status = rkx_pkg::STATUS_BAD_MAGIC;
                end
            end else begin
                n_key                = key_next;
                n_pos                = cur_pos + 2'd1;
                has_job              = 1'b1;
                o_job.res.data       = cipher;
                o_job.res.data_valid = 1'b1;
                o_job.res.last       = i_last;
                o_job.res.status     = rkx_pkg::STATUS_OK;
                o_job.res.rkey       = r_shift[63:32];
            end
        end else begin
            if (r_count == 4'd0) begin
                n_count       = rkx_pkg::HEADER_LEN;
                o_job.hdr     = !i_cfg.decrypt_mode && i_cfg.header_enable;
                o_job.magic   = i_cfg.magic_word;
                o_job.hdr_key = i_cfg.key_seed ^ i_cfg.key_mask;
            end
            n_key                = key_next;
            n_pos                = cur_pos + 2'd1;
            has_job              = 1'b1;
            o_job.res.data       = cipher;
            o_job.res.data_valid = 1'b1;
            o_job.res.last       = i_last;
            o_job.res.status     = rkx_pkg::STATUS_OK;
        end

        if (i_last) begin
            n_key   = i_cfg.key_seed;
            n_pos   = 2'd0;
            n_count = 4'd0;
            n_shift = '0;
            n_err   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key   <= '0;
            r_pos   <= '0;
            r_count <= '0;
            r_shift <= '0;
            r_err   <= 1'b0;
        end else if (accept) begin
            r_key   <= n_key;
            r_pos   <= n_pos;
            r_count <= n_count;
            r_shift <= n_shift;
            r_err   <= n_err;
        end
    end

    `RKX_ASSERT_NOW(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= rkx_pkg::HEADER_LEN)
    `RKX_ASSERT_NEXT(a_last_clears, i_clk, i_rst_n, accept && i_last,
                     (r_count == 4'd0) && !r_err && (r_pos == 2'd0))

endmodule

/* src/rkx_back.sv */
// ----------------------------------------------------------------------------
// rkx_back
// Expands queued jobs into result transfers through an output register.
// ----------------------------------------------------------------------------
`include "rolling_key_xor_stream_cipher_defines.svh"

module rkx_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rkx_pkg::t_job    i_head,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output rkx_pkg::t_result o_res
);

    logic             r_out_valid;
    rkx_pkg::t_result r_out, n_out;
    logic [3:0]       r_idx, n_idx;
    logic             load;
    logic             in_header;
    logic [63:0]      hdr_words;
    logic [63:0]      hdr_sh;

    assign load      = !i_empty && (!r_out_valid || i_out_ready);
    assign in_header = i_head.hdr && (r_idx != rkx_pkg::HEADER_LEN);
    assign o_pop     = load && !in_header;
    assign hdr_words = {i_head.hdr_key, i_head.magic};
    assign hdr_sh    = hdr_words >> {r_idx[2:0], 3'b000};

    always_comb begin
        n_out = i_head.res;
        n_idx = r_idx;
        if (in_header) begin
            n_out.data       = hdr_sh[7:0];
            n_out.data_valid = 1'b1;
            n_out.last       = 1'b0;
            n_out.status     = rkx_pkg::STATUS_OK;
            n_out.rkey       = '0;
            n_idx            = r_idx + 4'd1;
        end else begin
            n_idx = 4'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_idx       <= n_idx;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_res       = r_out;

    `RKX_ASSERT_NOW(a_idx_holds_job, i_clk, i_rst_n, r_idx != 4'd0, !i_empty && i_head.hdr)
    `RKX_ASSERT_NOW(a_nodata_is_last, i_clk, i_rst_n, r_out_valid && !r_out.data_valid,
                    r_out.last)

endmodule

/* src/rolling_key_xor_stream_cipher.sv */
// Results pass through the job queue and then the output register. Throughput: one
// byte per cycle while the queue has room; the first byte of a header-encrypted
// message yields nine results (eight header bytes and the cipher byte). The rate is
// set by the output stage: one result per cycle while the result channel is ready.
// Reset is synchronous and active low: registers return to their defaults, the
// running key to zero and the job queue and output stage empty.
// ----------------------------------------------------------------------------
// rolling_key_xor_stream_cipher
// Byte-stream cipher with a 32-bit rolling key and an optional key header.
// ----------------------------------------------------------------------------
module rolling_key_xor_stream_cipher #(
    parameter int unsigned QUEUE_DEPTH = rkx_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // Input byte channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_in,
    input  logic        i_last_in,
    // Result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_out,
    output logic        o_data_valid,
    output logic        o_last_out,
    output logic [1:0]  o_status,
    output logic [31:0] o_recovered_key
);

    // The configuration registers live here. A write transfer updates the
    // register selected by the index; indices beyond the list are dropped.
    rkx_pkg::t_cfg    r_cfg;
    rkx_pkg::t_job    push_job;
    rkx_pkg::t_job    head_job;
    rkx_pkg::t_result res;
    logic             push, pop, q_empty, q_full;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.key_seed      <= '0;
            r_cfg.decrypt_mode  <= 1'b0;
            r_cfg.header_enable <= 1'b0;
            r_cfg.key_mask      <= '0;
            r_cfg.magic_word    <= rkx_pkg::MAGIC_DEFAULT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rkx_pkg::REG_KEY_SEED:      r_cfg.key_seed      <= i_cfg_data;
                rkx_pkg::REG_DECRYPT_MODE:  r_cfg.decrypt_mode  <= i_cfg_data[0];
                rkx_pkg::REG_HEADER_ENABLE: r_cfg.header_enable <= i_cfg_data[0];
                rkx_pkg::REG_KEY_MASK:      r_cfg.key_mask      <= i_cfg_data;
                rkx_pkg::REG_MAGIC_WORD:    r_cfg.magic_word    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Front part: takes one byte per transfer, advances the key and header
    // state at once, and queues a job for every byte that yields results.
    rkx_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_data       (i_data_in),
        .i_last       (i_last_in),
        .i_queue_full (q_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    // The queue lets the front keep accepting bytes while the back is busy
    // with header bytes or held up by the result channel.
    rkx_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // Back part: turns each job into one or nine result transfers through
    // a registered output stage.
    rkx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head_job),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (res)
    );

    assign o_data_out      = res.data;
    assign o_data_valid    = res.data_valid;
    assign o_last_out      = res.last;
    assign o_status        = res.status;
    assign o_recovered_key = res.rkey;

endmodule
